@@ src/ccs_pkg.sv @@
// ---------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the C comment stripper
// Scan modes, character codes, beat payloads and the front-to-back entry.
// ---------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  // character codes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // entry queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // scanner modes
  typedef enum logic [3:0] {
    MODE_CODE       = 4'd0,
    MODE_SLASH      = 4'd1,
    MODE_LINE       = 4'd2,
    MODE_BLOCK      = 4'd3,
    MODE_BLOCK_STAR = 4'd4,
    MODE_STR        = 4'd5,
    MODE_STR_ESC    = 4'd6,
    MODE_CHR        = 4'd7,
    MODE_CHR_ESC    = 4'd8
  } mode_t;

  // input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;
  } out_beat_t;

  // one classified input: up to two result bytes
  typedef struct packed {
    logic       two_res;
    logic       has_byte;
    logic       done;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } entry_t;

  // queue status seen by the top level and back
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ src/ccs_front.sv @@
// ---------------------------------------------------------------------------
// ccs_front: byte classifier
// Runs the scan-mode state machine on each accepted byte and pushes the
// resulting bytes, if any, and the end-of-text flag into the entry queue as one entry.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_front
  import ccs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_acc,
  input  wire in_beat_t in_data,
  output logic          push,
  output entry_t        push_entry,
  output mode_t         scan_mode
);

  mode_t      mode_r, mode_nxt, mode_scan;
  logic [1:0] n_emit;
  logic [7:0] e0, e1;
  logic [7:0] c;

  assign c         = in_data.in_byte;
  assign scan_mode = mode_r;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CODE;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
    end
  end

  // per-byte decision
  always_comb begin
    mode_scan = mode_r;
    n_emit    = 2'd0;
    e0        = 8'h00;
    e1        = 8'h00;
    unique case (mode_r)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_scan = MODE_LINE;
        end else if (c == CH_STAR) begin
          mode_scan = MODE_BLOCK;
        end else begin
          // held slash goes out first, then the byte as plain code
          e0     = CH_SLASH;
          e1     = c;
          n_emit = 2'd2;
          if (c == CH_DQUOTE) begin
            mode_scan = MODE_STR;
          end else if (c == CH_SQUOTE) begin
            mode_scan = MODE_CHR;
          end else begin
            mode_scan = MODE_CODE;
          end
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          e0        = c;
          n_emit    = 2'd1;
          mode_scan = MODE_CODE;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (mode_r == MODE_BLOCK_STAR && c == CH_SLASH) begin
          e0        = CH_SPACE;
          n_emit    = 2'd1;
          mode_scan = MODE_CODE;
        end else if (c == CH_STAR) begin
          mode_scan = MODE_BLOCK_STAR;
        end else begin
          if (c == CH_NL) begin
            e0     = c;
            n_emit = 2'd1;
          end
          mode_scan = MODE_BLOCK;
        end
      end
      MODE_STR: begin
        e0     = c;
        n_emit = 2'd1;
        if (c == CH_BSLASH) begin
          mode_scan = MODE_STR_ESC;
        end else if (c == CH_DQUOTE) begin
          mode_scan = MODE_CODE;
        end
      end
      MODE_STR_ESC: begin
        e0        = c;
        n_emit    = 2'd1;
        mode_scan = MODE_STR;
      end
      MODE_CHR: begin
        e0     = c;
        n_emit = 2'd1;
        if (c == CH_BSLASH) begin
          mode_scan = MODE_CHR_ESC;
        end else if (c == CH_SQUOTE) begin
          mode_scan = MODE_CODE;
        end
      end
      MODE_CHR_ESC: begin
        e0        = c;
        n_emit    = 2'd1;
        mode_scan = MODE_CHR;
      end
      default: begin
        // normal code
        if (c == CH_SLASH) begin
          mode_scan = MODE_SLASH;
        end else begin
          e0     = c;
          n_emit = 2'd1;
          if (c == CH_DQUOTE) begin
            mode_scan = MODE_STR;
          end else if (c == CH_SQUOTE) begin
            mode_scan = MODE_CHR;
          end else begin
            mode_scan = MODE_CODE;
          end
        end
      end
    endcase

    // end of text: flush a held slash and fall back to code
    mode_nxt = mode_scan;
    if (in_data.end_of_text) begin
      if (mode_scan == MODE_SLASH) begin
        if (n_emit == 2'd0) begin
          e0     = CH_SLASH;
          n_emit = 2'd1;
        end else begin
          e1     = CH_SLASH;
          n_emit = 2'd2;
        end
      end
      mode_nxt = MODE_CODE;
    end
  end

  // entry toward the back
  always_comb begin
    push                   = in_acc && ((n_emit != 2'd0) || in_data.end_of_text);
    push_entry.two_res     = (n_emit == 2'd2);
    push_entry.has_byte    = (n_emit != 2'd0);
    push_entry.done        = in_data.end_of_text;
    push_entry.first_byte  = e0;
    push_entry.second_byte = e1;
  end

endmodule

`default_nettype wire

@@ src/ccs_queue.sv @@
// ---------------------------------------------------------------------------
// ccs_queue: entry queue
// Small fifo that decouples the classifier from the result sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_queue
  import ccs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output q_stat_t     stat
);

  entry_t           mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full     = (count_r == (QAW+1)'(QDEPTH));
  assign stat.nonempty = (count_r != '0);
  assign do_push       = push && !stat.full;
  assign do_pop        = pop && stat.nonempty;
  assign head          = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/ccs_back.sv @@
// ---------------------------------------------------------------------------
// ccs_back: result sequencer
// Turns each queued entry into one or two result beats through an output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_back
  import ccs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire entry_t  head,
  input  wire q_stat_t stat,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_beat_t    out_data,
  output logic         second_phase
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  logic      phase_r, phase_nxt;
  logic      load;

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign second_phase = phase_r;
  assign load         = !out_valid_r || !out_stall;

  // next beat selection
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = stat.nonempty;
      if (stat.nonempty) begin
        if (head.two_res && !phase_r) begin
          // first of two bytes
          out_data_nxt.out_byte   = head.first_byte;
          out_data_nxt.byte_valid = 1'b1;
          out_data_nxt.run_last   = 1'b0;
          out_data_nxt.text_done  = 1'b0;
          phase_nxt               = 1'b1;
        end else begin
          // single byte, second byte or empty end marker
          out_data_nxt.out_byte   = phase_r ? head.second_byte : head.first_byte;
          out_data_nxt.byte_valid = head.has_byte;
          out_data_nxt.run_last   = 1'b1;
          out_data_nxt.text_done  = head.done;
          phase_nxt               = 1'b0;
          pop                     = 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ src/c_comment_stripper.sv @@
// ---------------------------------------------------------------------------
// c_comment_stripper: C comment removal
// Strips line and block comments from a byte stream, keeping literals.
// ---------------------------------------------------------------------------
//  channel  ports                          beat
//  input    in_valid in_stall in_data      in_byte, end_of_text
//  result   out_valid out_stall out_data   out_byte, byte_valid, run_last,
//                                          text_done
//
//  one input byte is classified per cycle while in_stall is low; its first
//  result is written into the queue when the byte is accepted and then
//  passes through the output register to out_valid
//  a two-result byte holds the sequencer for both results; the held slash
//  before it yielded none, so with out_stall low one byte per cycle is sustained
//  in_stall rises only when the four-entry queue is full
//  synchronous active-low reset returns the scanner to normal code and
//  empties the queue
// ---------------------------------------------------------------------------
`default_nettype none

module c_comment_stripper
  import ccs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  logic    in_acc;
  logic    push, pop;
  entry_t  push_entry, head;
  q_stat_t stat;
  mode_t   scan_mode;
  logic    second_phase;

  // input handshake
  assign in_stall = stat.full;
  assign in_acc   = in_valid && !in_stall;

  ccs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_data    (in_data),
    .push       (push),
    .push_entry (push_entry),
    .scan_mode  (scan_mode)
  );

  ccs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  ccs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .second_phase (second_phase)
  );

  // end of text always leaves the scanner in normal code
  a_eot_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.end_of_text) |=> (scan_mode == MODE_CODE))
    else $error("scanner not back in code mode after end of text");

  // an empty beat is only the end marker
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.byte_valid) |->
      (out_data.run_last && out_data.text_done && (out_data.out_byte == 8'h00)))
    else $error("empty result beat that is not an end marker");

  // text end only on the last beat of an input
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.text_done) |-> out_data.run_last)
    else $error("text_done without run_last");

  // second half pending means its entry is still queued
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    second_phase |-> (stat.nonempty && head.two_res))
    else $error("second result pending without a two-byte entry");

endmodule

`default_nettype wire
